[hw/rtl/assert_macros.svh]
// Assertion macros for the audio history ring.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AHR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define AHR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AHR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AHR_ASSERT(lbl, cond, msg)
`define AHR_ASSERT_IMP(lbl, ante, cons, msg)
`define AHR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/ahr_pkg.sv]
// Package for the audio history ring: sizes, command codes, payload types,
// controller states and the sample magnitude function. No dependencies.
package ahr_pkg;

    localparam int DEPTH       = 65536;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CAP_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 24;
    localparam int PEAK_W      = SAMPLE_BITS - 1;
    localparam int MAX_POINTS  = 64;
    localparam int POINT_W     = 7;
    localparam int ACC_W       = $clog2((DEPTH + 1) * (MAX_POINTS + 1));
    localparam int MOD_CNT_W   = $clog2(ADDR_W);
    localparam int WORD_W      = 2 * SAMPLE_BITS;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_REGION = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic KIND_PEAK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic [1:0]         channels_present;
        logic [16:0]        span;
        logic [15:0]        offset;
        logic [6:0]         point_count;
        logic [15:0]        index;
    } req_t;

    typedef struct packed {
        logic               result_kind;
        logic [22:0]        peak;
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_START1,
        ST_START2,
        ST_WALK,
        ST_REG_RD,
        ST_REG_OUT
    } state_t;

    // Magnitude of a sample; the most negative code saturates to full scale.
    function automatic logic [PEAK_W-1:0] mag(input logic signed [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] neg;
        begin
            neg = ~s + 1'b1;
            if (!s[SAMPLE_BITS-1])
            begin
                mag = s[PEAK_W-1:0];
            end
            else if (neg[SAMPLE_BITS-1])
            begin
                mag = '1;
            end
            else
            begin
                mag = neg[PEAK_W-1:0];
            end
        end
    endfunction

endpackage

[hw/rtl/audio_history_ring_with_peak_overview_top.sv]
// Push: accepted back to back while the reduced head is valid. Region read: the states
// START1, START2, REG_RD and REG_OUT, then the output register; ST_MOD runs before them
// when offset >= capacity (bit-serial remainder unit). Query: one memory read per frame,
// one result per bucket, ST_MOD likewise first; results wait in one output register.
// Reset: asynchronous, then clearing of all 65536 entries; a capacity write forces head
// reduction, by ST_MOD if the head lies beyond it. Uses ahr_pkg, assert_macros.svh.
`include "assert_macros.svh"

module audio_history_ring_with_peak_overview_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ahr_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ahr_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [16:0]                 cfg_wdata
);

    localparam int AW = ahr_pkg::ADDR_W;
    localparam int CW = ahr_pkg::CAP_W;
    localparam int PW = ahr_pkg::POINT_W;
    localparam int XW = ahr_pkg::ACC_W;
    localparam int SB = ahr_pkg::SAMPLE_BITS;

    logic [ahr_pkg::WORD_W-1:0] mem [ahr_pkg::DEPTH];
    logic [ahr_pkg::WORD_W-1:0] mem_rdata_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [ahr_pkg::WORD_W-1:0] mem_wdata;

    ahr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  capacity_reg;
    logic [CW-1:0]  cap_eff;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic           pos_ok_reg, pos_ok_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [AW-1:0]  mod_val_reg, mod_val_next;
    logic [AW-1:0]  mod_rem_reg, mod_rem_next;
    logic [ahr_pkg::MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic           mod_head_reg, mod_head_next;
    logic           region_reg, region_next;
    logic [CW-1:0]  span_reg, span_next;
    logic [AW-1:0]  off_reg, off_next;
    logic [PW-1:0]  pts_reg, pts_next;
    logic [AW-1:0]  index_reg, index_next;
    logic [AW-1:0]  tmp_reg, tmp_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [XW-1:0]  fp_reg, fp_next;
    logic [XW-1:0]  np_reg, np_next;
    logic [PW-1:0]  pt_reg, pt_next;
    logic [ahr_pkg::PEAK_W-1:0] peak_reg, peak_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           in_range_reg, in_range_next;
    ahr_pkg::rsp_t  rsp_reg, rsp_next;
    logic           rsp_valid_reg;
    logic           rsp_load;

    logic           accept;
    logic           slot_free;
    logic           head_ok;
    logic [PW-1:0]  pts_in;
    logic [CW-1:0]  span_in;
    logic [CW-1:0]  mod_step;
    logic [AW-1:0]  mod_res;
    logic [ahr_pkg::PEAK_W-1:0] peak_now;
    logic [ahr_pkg::PEAK_W-1:0] mag_l, mag_r;
    logic [CW:0]    sum_w;
    logic           walk_read;
    logic           last_pt;

    // Effective capacity: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (capacity_reg > CW'(ahr_pkg::DEPTH))
        begin
            cap_eff = CW'(ahr_pkg::DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    // The raw head is kept; pos_reg holds it reduced to the current capacity
    assign head_ok   = pos_ok_reg;
    assign req_ready = (state_reg == ahr_pkg::ST_IDLE) && head_ok;
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign pts_in    = (req.point_count > PW'(ahr_pkg::MAX_POINTS))
                       ? PW'(ahr_pkg::MAX_POINTS) : req.point_count;
    assign span_in   = (req.span > cap_eff) ? cap_eff : req.span;

    // One restoring remainder step against the capacity
    assign mod_step = {mod_rem_reg, mod_val_reg[AW-1]};
    assign mod_res  = (mod_step >= cap_eff) ? AW'(mod_step - cap_eff) : AW'(mod_step);

    // Fold the frame read last cycle into the running bucket peak
    assign mag_l = ahr_pkg::mag(mem_rdata_reg[2*SB-1:SB]);
    assign mag_r = ahr_pkg::mag(mem_rdata_reg[SB-1:0]);
    always_comb
    begin
        peak_now = peak_reg;
        if (rd_pend_reg)
        begin
            if (mag_l > peak_now)
            begin
                peak_now = mag_l;
            end
            if (mag_r > peak_now)
            begin
                peak_now = mag_r;
            end
        end
    end

    assign walk_read = fp_reg <= np_reg;
    assign last_pt   = pt_reg == (pts_reg - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahr_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ahr_pkg::ST_IDLE;
                end
            end
            ahr_pkg::ST_IDLE:
            begin
                if (!head_ok)
                begin
                    if ({1'b0, head_reg} >= cap_eff)
                    begin
                        state_next = ahr_pkg::ST_MOD;
                    end
                end
                else if (accept)
                begin
                    if ((req.cmd == ahr_pkg::CMD_REGION) ||
                        ((req.cmd == ahr_pkg::CMD_QUERY) && (pts_in != '0)))
                    begin
                        state_next = ({1'b0, req.offset} < cap_eff)
                                     ? ahr_pkg::ST_START1 : ahr_pkg::ST_MOD;
                    end
                end
            end
            ahr_pkg::ST_MOD:
            begin
                if (mod_cnt_reg == '0)
                begin
                    state_next = mod_head_reg ? ahr_pkg::ST_IDLE : ahr_pkg::ST_START1;
                end
            end
            ahr_pkg::ST_START1:
            begin
                state_next = ahr_pkg::ST_START2;
            end
            ahr_pkg::ST_START2:
            begin
                state_next = region_reg ? ahr_pkg::ST_REG_RD : ahr_pkg::ST_WALK;
            end
            ahr_pkg::ST_WALK:
            begin
                if (!walk_read && slot_free && last_pt)
                begin
                    state_next = ahr_pkg::ST_IDLE;
                end
            end
            ahr_pkg::ST_REG_RD:
            begin
                state_next = ahr_pkg::ST_REG_OUT;
            end
            ahr_pkg::ST_REG_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ahr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ahr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        head_next     = head_reg;
        pos_next      = pos_reg;
        pos_ok_next   = pos_ok_reg;
        clr_next      = clr_reg;
        mod_val_next  = mod_val_reg;
        mod_rem_next  = mod_rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        mod_head_next = mod_head_reg;
        region_next   = region_reg;
        span_next     = span_reg;
        off_next      = off_reg;
        pts_next      = pts_reg;
        index_next    = index_reg;
        tmp_next      = tmp_reg;
        ptr_next      = ptr_reg;
        fp_next       = fp_reg;
        np_next       = np_reg;
        pt_next       = pt_reg;
        peak_next     = peak_now;
        rd_pend_next  = 1'b0;
        in_range_next = in_range_reg;
        rsp_next      = rsp_reg;
        rsp_load      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = ptr_reg;
        mem_wdata     = '0;
        sum_w         = '0;
        unique case (state_reg)
            ahr_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ahr_pkg::ST_IDLE:
            begin
                if (!head_ok)
                begin
                    if ({1'b0, head_reg} < cap_eff)
                    begin
                        pos_next    = head_reg;
                        pos_ok_next = 1'b1;
                    end
                    else
                    begin
                        mod_val_next  = head_reg;
                        mod_rem_next  = '0;
                        mod_cnt_next  = ahr_pkg::MOD_CNT_W'(AW - 1);
                        mod_head_next = 1'b1;
                    end
                end
                else if (accept)
                begin
                    region_next   = req.cmd == ahr_pkg::CMD_REGION;
                    span_next     = span_in;
                    off_next      = req.offset;
                    pts_next      = pts_in;
                    index_next    = req.index;
                    mod_val_next  = req.offset;
                    mod_rem_next  = '0;
                    mod_cnt_next  = ahr_pkg::MOD_CNT_W'(AW - 1);
                    mod_head_next = 1'b0;
                    if (req.cmd == ahr_pkg::CMD_PUSH)
                    begin
                        mem_we   = 1'b1;
                        mem_addr = pos_reg;
                        mem_wdata[2*SB-1:SB] = (req.channels_present >= 2'd1)
                                               ? req.left_sample : '0;
                        mem_wdata[SB-1:0]    = (req.channels_present >= 2'd2)
                                               ? req.right_sample : '0;
                        head_next = (({1'b0, pos_reg} + 1'b1) == cap_eff)
                                    ? '0 : pos_reg + 1'b1;
                        pos_next  = (({1'b0, pos_reg} + 1'b1) == cap_eff)
                                    ? '0 : pos_reg + 1'b1;
                    end
                end
            end
            ahr_pkg::ST_MOD:
            begin
                mod_rem_next = mod_res;
                mod_val_next = {mod_val_reg[AW-2:0], 1'b0};
                mod_cnt_next = mod_cnt_reg - 1'b1;
                if (mod_cnt_reg == '0)
                begin
                    if (mod_head_reg)
                    begin
                        pos_next    = mod_res;
                        pos_ok_next = 1'b1;
                    end
                    else
                    begin
                        off_next = mod_res;
                    end
                end
            end
            ahr_pkg::ST_START1:
            begin
                // head minus offset, wrapped into the ring
                if (pos_reg >= off_reg)
                begin
                    tmp_next = pos_reg - off_reg;
                end
                else
                begin
                    sum_w    = {1'b0, cap_eff} + {2'b0, pos_reg} - {2'b0, off_reg};
                    tmp_next = AW'(sum_w);
                end
            end
            ahr_pkg::ST_START2:
            begin
                // step back over the window length to its oldest frame
                if ({1'b0, tmp_reg} >= span_reg)
                begin
                    sum_w = {2'b0, tmp_reg} - {1'b0, span_reg};
                end
                else
                begin
                    sum_w = {1'b0, cap_eff} + {2'b0, tmp_reg} - {1'b0, span_reg};
                end
                ptr_next  = AW'(sum_w);
                fp_next   = XW'(pts_reg);
                np_next   = XW'(span_reg);
                pt_next   = '0;
                peak_next = '0;
            end
            ahr_pkg::ST_WALK:
            begin
                if (walk_read)
                begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    fp_next      = fp_reg + XW'(pts_reg);
                    ptr_next     = (({1'b0, ptr_reg} + 1'b1) == cap_eff)
                                   ? '0 : ptr_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    rsp_load             = 1'b1;
                    rsp_next.result_kind = ahr_pkg::KIND_PEAK;
                    rsp_next.peak        = peak_now;
                    rsp_next.left_out    = '0;
                    rsp_next.right_out   = '0;
                    rsp_next.last        = last_pt;
                    peak_next            = '0;
                    pt_next              = pt_reg + 1'b1;
                    np_next              = np_reg + XW'(span_reg);
                end
            end
            ahr_pkg::ST_REG_RD:
            begin
                in_range_next = {1'b0, index_reg} < span_reg;
                sum_w         = {2'b0, ptr_reg} + {2'b0, index_reg};
                if (sum_w >= {1'b0, cap_eff})
                begin
                    sum_w = sum_w - {1'b0, cap_eff};
                end
                mem_addr = AW'(sum_w);
                mem_re   = {1'b0, index_reg} < span_reg;
            end
            ahr_pkg::ST_REG_OUT:
            begin
                if (slot_free)
                begin
                    rsp_load             = 1'b1;
                    rsp_next.result_kind = ahr_pkg::KIND_FRAME;
                    rsp_next.peak        = '0;
                    rsp_next.left_out    = in_range_reg ? mem_rdata_reg[2*SB-1:SB] : '0;
                    rsp_next.right_out   = in_range_reg ? mem_rdata_reg[SB-1:0] : '0;
                    rsp_next.last        = 1'b1;
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // History store: single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahr_pkg::ST_CLEAR;
            capacity_reg  <= CW'(ahr_pkg::DEPTH);
            head_reg      <= '0;
            pos_reg       <= '0;
            pos_ok_reg    <= 1'b1;
            clr_reg       <= '0;
            mod_cnt_reg   <= '0;
            mod_head_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            pos_reg      <= pos_next;
            clr_reg      <= clr_next;
            mod_cnt_reg  <= mod_cnt_next;
            mod_head_reg <= mod_head_next;
            rd_pend_reg  <= rd_pend_next;
            // a new capacity invalidates the reduced head
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
                pos_ok_reg   <= 1'b0;
            end
            else
            begin
                pos_ok_reg   <= pos_ok_next;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mod_val_reg  <= mod_val_next;
        mod_rem_reg  <= mod_rem_next;
        region_reg   <= region_next;
        span_reg     <= span_next;
        off_reg      <= off_next;
        pts_reg      <= pts_next;
        index_reg    <= index_next;
        tmp_reg      <= tmp_next;
        ptr_reg      <= ptr_next;
        fp_reg       <= fp_next;
        np_reg       <= np_next;
        pt_reg       <= pt_next;
        peak_reg     <= peak_next;
        in_range_reg <= in_range_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `AHR_ASSERT_IMP(a_head_in_ring, accept, {1'b0, pos_reg} < cap_eff, "head beyond ring")
    `AHR_ASSERT_IMP(a_read_in_ring, mem_re, {1'b0, mem_addr} < cap_eff, "read outside the ring")
    `AHR_ASSERT_NXT(a_last_ends_item, rsp_load && rsp_next.last, state_reg == ahr_pkg::ST_IDLE, "final result did not end the item")
    `AHR_ASSERT_IMP(a_pend_use, rd_pend_reg, (state_reg == ahr_pkg::ST_WALK) || (state_reg == ahr_pkg::ST_REG_OUT), "read data with no consumer")

endmodule
